// File: src/fmat_pkg.sv
package fmat_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int PAGE_BITS   = 12;
    localparam int FLASH_PAGES = 8192;

    // Field widths
    localparam int IDX_W   = 10;
    localparam int PAGE_W  = 13;
    localparam int POS_W   = 25;
    localparam int ADR_W   = 32;
    localparam int PREQ_W  = POS_W - PAGE_BITS;
    localparam int ENTRY_W = 2 * PAGE_W;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAGMENT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_BASE     = 1'b1;
    localparam logic [ADR_W-1:0]     FLASH_BASE_RESET   = 32'hA000_0000;

    // Request action codes
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_LOADED = 2'd0,
        ST_FOUND  = 2'd1,
        ST_MISS   = 2'd2
    } t_status;

    typedef struct packed {
        logic              action;
        logic [IDX_W-1:0]  entry_index;
        logic [PAGE_W-1:0] entry_first_page;
        logic [PAGE_W-1:0] entry_page_count;
        logic [POS_W-1:0]  read_position;
        logic [POS_W-1:0]  request_size;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [ADR_W-1:0]  flash_address;
        logic [POS_W-1:0]  chunk_length;
    } t_out_item;

    // One table entry: page count over first page
    typedef struct packed {
        logic [PAGE_W-1:0] page_count;
        logic [PAGE_W-1:0] first_page;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic    accept;
        logic    walk;
        logic    res_load;
        t_status res_kind;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic hit;
        logic miss;
    } t_dp_status;

endpackage

// File: src/fmat_in_if.sv
interface fmat_in_if import fmat_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// File: src/fmat_out_if.sv
interface fmat_out_if import fmat_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// File: src/fmat_ram.sv
module fmat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/fmat_ctrl.sv
module fmat_ctrl import fmat_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_action,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_cmd       o_cmd,
    input  t_dp_status i_stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_RESULT
    } t_state;

    t_state  r_state;
    t_status r_kind;
    logic    r_out_valid;
    logic    accept;
    logic    res_load;

    // Result register is free when empty or being drained this cycle
    assign accept   = (r_state == S_IDLE) && i_in_valid;
    assign res_load = (r_state == S_RESULT) && (!r_out_valid || i_out_ready);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    assign o_cmd.accept   = accept;
    assign o_cmd.walk     = (r_state == S_WALK);
    assign o_cmd.res_load = res_load;
    assign o_cmd.res_kind = r_kind;

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= ST_LOADED;
            r_out_valid <= 1'b0;
        end else begin
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_in_action == ACT_LOAD) begin
                            r_kind  <= ST_LOADED;
                            r_state <= S_RESULT;
                        end else begin
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (i_stat.hit) begin
                        r_kind  <= ST_FOUND;
                        r_state <= S_RESULT;
                    end else if (i_stat.miss) begin
                        r_kind  <= ST_MISS;
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (res_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: src/fmat_dp.sv
module fmat_dp import fmat_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_item,
    input  t_cmd                  i_cmd,
    output t_dp_status            o_stat,
    output t_out_item             o_item
);

    // Configuration
    logic [CNT_W-1:0]  r_frag_count;
    logic [ADR_W-1:0]  r_flash_base;

    // Walk state
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_limit;
    logic              r_pend;
    logic [PREQ_W-1:0] r_page_req;
    logic [PAGE_BITS-1:0] r_pos_low;
    logic [POS_W-1:0]  r_req;

    // Captured hit
    logic [PAGE_W-1:0] r_first;
    logic [PAGE_W-1:0] r_rem;

    t_out_item         r_out;
    t_out_item         n_out;

    logic              ram_we;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry            entry;
    t_entry            wr_entry;
    logic              hit;
    logic              more;
    logic [POS_W-1:0]  len;
    logic [ADR_W-1:0]  addr;

    // Table storage
    assign wr_entry.page_count = i_item.entry_page_count;
    assign wr_entry.first_page = i_item.entry_first_page;
    assign ram_we = i_cmd.accept && (i_item.action == ACT_LOAD)
                    && (32'(i_item.entry_index) < TABLE_DEPTH);

    fmat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ADDR_W'(i_item.entry_index)),
        .i_wdata (wr_entry),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign entry = t_entry'(ram_rdata);

    // Entry compare: data returned for the read issued last cycle
    assign more        = (r_idx < r_limit);
    assign hit         = r_pend && (r_page_req < entry.page_count);
    assign o_stat.hit  = hit;
    assign o_stat.miss = !r_pend && !more;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frag_count <= '0;
            r_flash_base <= FLASH_BASE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAGMENT_COUNT: r_frag_count <= i_cfg_data[CNT_W-1:0];
                CFG_FLASH_BASE:     r_flash_base <= i_cfg_data[ADR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Walk: issue one read a cycle, subtract page counts until a hit or the last entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_idx  <= '0;
        end else if (i_cmd.accept) begin
            r_pend <= 1'b0;
            r_idx  <= '0;
        end else if (i_cmd.walk) begin
            r_pend <= more;
            if (more) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_page_req <= i_item.read_position[POS_W-1:PAGE_BITS];
            r_pos_low  <= i_item.read_position[PAGE_BITS-1:0];
            r_req      <= i_item.request_size;
            r_limit    <= (32'(r_frag_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                            : r_frag_count;
        end else if (i_cmd.walk && r_pend) begin
            if (hit) begin
                r_first <= entry.first_page;
                r_rem   <= entry.page_count - r_page_req;
            end else begin
                r_page_req <= r_page_req - entry.page_count;
            end
        end
    end

    // Result: address and clamped length of the hit fragment
    assign addr = r_flash_base
                + (ADR_W'(r_first) << PAGE_BITS)
                + ADR_W'({r_page_req, r_pos_low});
    assign len  = (POS_W'(r_rem) << PAGE_BITS) - POS_W'(r_pos_low);

    always_comb begin
        n_out.status        = i_cmd.res_kind;
        n_out.flash_address = '0;
        n_out.chunk_length  = '0;
        if (i_cmd.res_kind == ST_FOUND) begin
            n_out.flash_address = addr;
            n_out.chunk_length  = (len > r_req) ? r_req : len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out <= n_out;
        end
    end

    assign o_item = r_out;

endmodule

// File: src/fragment_map_address_translator.sv
// Fragment map address translator. Load requests write one entry (first flash
// page, page count) of a 1024-entry fragment table; lookup requests translate a
// file byte position into a flash byte address and a contiguous length clamped
// to the request size, or report that the position lies beyond the mapped
// fragments. One request is in work at a time. A load skips the table walk and
// goes straight to the result. A lookup reads the table one entry per cycle
// through the table RAM's registered read port and ends at the first hit, or
// with a miss once min(fragment_count, 1024) entries have been walked; the walk
// length sets the rate. A result held by the output stalls the next result until
// it is taken. A new request is taken while the previous result waits at the
// output. Table contents are undefined after reset, and every slot below
// fragment_count must be loaded before a lookup walks it. Configuration may be
// written only while the block is idle.
module fragment_map_address_translator import fmat_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    fmat_in_if.sink               i_in,
    fmat_out_if.source            o_out
);

    t_cmd       cmd;
    t_dp_status stat;

    fmat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.item.action),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    fmat_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in.item),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_item     (o_out.item)
    );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import fmat_pkg::*;

    // Slots loaded before the random phases; deep walks stay below this
    localparam int FILL_SLOTS = 300;

    // Directed script row kinds
    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_LOOKUP,
        ROW_SET_COUNT,
        ROW_SET_BASE
    } t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [ADR_W-1:0] arg;      // slot, or register value
        logic [POS_W-1:0] arg_b;    // first page, or file position
        logic [POS_W-1:0] arg_c;    // page count, or request size
        logic             fixed;    // use the typed-in result below
        t_out_item        want;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    fmat_in_if  in_ch();
    fmat_out_if out_ch();

    fragment_map_address_translator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Shadow copy of the translator state
    t_entry             frag_table [TABLE_DEPTH];
    logic [CNT_W-1:0]   frag_count;
    logic [ADR_W-1:0]   frag_base;

    t_out_item          awaited_results [$];
    t_dir_row           script [$];
    bit                 steady;
    int unsigned        out_hold;
    int unsigned        n_errors, n_loads, n_lookups, n_found, n_beyond, n_reg_writes;
    t_out_item          got, want;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("fragment_map_address_translator regression: fail");
        $finish;
    end

    task automatic flag_mismatch(string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        n_errors++;
    endtask

    // Expected result of one request; loads update the shadow table
    function automatic t_out_item translate_request(t_in_item req);
        t_out_item         res;
        int unsigned       walk_len;
        int unsigned       i;
        logic [PREQ_W-1:0] page_left;
        logic [POS_W-1:0]  offset;
        logic [POS_W-1:0]  room;
        res = '{status: ST_LOADED, flash_address: '0, chunk_length: '0};
        if (req.action == ACT_LOAD) begin
            frag_table[req.entry_index] = '{page_count: req.entry_page_count,
                                            first_page: req.entry_first_page};
            return res;
        end
        walk_len  = (frag_count > TABLE_DEPTH) ? TABLE_DEPTH : frag_count;
        page_left = req.read_position[POS_W-1:PAGE_BITS];
        res.status = ST_MISS;
        for (i = 0; i < walk_len; i++) begin
            // empty fragments never match since page_left < 0 is impossible
            if (page_left < frag_table[i].page_count) begin
                offset = {page_left, req.read_position[PAGE_BITS-1:0]};
                room   = {frag_table[i].page_count, {PAGE_BITS{1'b0}}} - offset;
                res.status        = ST_FOUND;
                res.flash_address = frag_base
                                  + ADR_W'({frag_table[i].first_page, {PAGE_BITS{1'b0}}})
                                  + ADR_W'(offset);
                res.chunk_length  = (room > req.request_size) ? req.request_size : room;
                return res;
            end
            page_left -= frag_table[i].page_count;
        end
        return res;
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_dir_row mk_row(t_row_kind kind, logic [ADR_W-1:0] arg,
                                        logic [POS_W-1:0] arg_b, logic [POS_W-1:0] arg_c,
                                        logic fixed, t_status st,
                                        logic [ADR_W-1:0] adr, logic [POS_W-1:0] len);
        t_dir_row row;
        row.kind  = kind;
        row.arg   = arg;
        row.arg_b = arg_b;
        row.arg_c = arg_c;
        row.fixed = fixed;
        row.want  = '{status: st, flash_address: adr, chunk_length: len};
        return row;
    endfunction

    // Random request with noise in the fields the action ignores
    function automatic t_in_item make_request();
        t_in_item          req;
        int unsigned       walk_len, total, ceiling, lim, i;
        logic [PREQ_W-1:0] page;
        logic [PAGE_BITS-1:0] in_page;
        int unsigned       r;
        req.action           = ($urandom_range(0, 9) < 4) ? ACT_LOAD : ACT_LOOKUP;
        req.entry_index      = IDX_W'($urandom);
        req.entry_first_page = PAGE_W'($urandom);
        req.entry_page_count = PAGE_W'($urandom);
        req.read_position    = POS_W'($urandom);
        req.request_size     = POS_W'($urandom);
        if (req.action == ACT_LOAD) begin
            lim = (frag_count > TABLE_DEPTH) ? TABLE_DEPTH : frag_count;
            if (lim != 0 && $urandom_range(0, 9) < 7)
                req.entry_index = IDX_W'($urandom_range(0, lim - 1));
            r = $urandom_range(0, 9);
            if (r < 3)
                req.entry_page_count = '0;
            else if (r < 7)
                req.entry_page_count = PAGE_W'($urandom_range(1, 8));
            else if (r == 9)
                req.entry_page_count = '1;
            if ($urandom_range(0, 9) == 0)
                req.entry_first_page = ($urandom_range(0, 1) == 0) ? '0 : '1;
            return req;
        end
        // Aim most lookups inside the mapped span, a little past its end
        walk_len = (frag_count > TABLE_DEPTH) ? TABLE_DEPTH : frag_count;
        total = 0;
        for (i = 0; i < walk_len; i++)
            total += frag_table[i].page_count;
        ceiling = (total < 8191) ? total : 8191;
        if ($urandom_range(0, 9) != 0) begin
            page    = PREQ_W'($urandom_range(0, ceiling));
            in_page = PAGE_BITS'($urandom);
            req.read_position = {page, in_page};
        end
        r = $urandom_range(0, 9);
        if (r == 0)
            req.request_size = '0;
        else if (r == 1)
            req.request_size = '1;
        else if (r < 6)
            req.request_size = POS_W'($urandom_range(1, 8192));
        return req;
    endfunction

    // Offer one request and record its expected result on acceptance
    task automatic send_request(t_in_item req, int unsigned gap, bit typed,
                                t_out_item typed_res);
        t_out_item res;
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.item  <= req;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        res = translate_request(req);
        awaited_results.push_back(typed ? typed_res : res);
        if (req.action == ACT_LOAD)
            n_loads++;
        else
            n_lookups++;
    endtask

    task automatic wait_until_idle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_until_idle();
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        if (idx == CFG_FRAGMENT_COUNT)
            frag_count = data[CNT_W-1:0];
        else
            frag_base = data;
        n_reg_writes++;
    endtask

    // Result side: random back-pressure
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (out_hold > 0) begin
                out_ch.ready <= 1'b0;
                out_hold--;
            end else begin
                out_ch.ready <= 1'b1;
                out_hold = pick_gap();
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.item;
            if (awaited_results.size() == 0) begin
                flag_mismatch($sformatf("result with nothing pending, status %0d",
                                        got.status));
            end else begin
                want = awaited_results.pop_front();
                if (got.status !== want.status)
                    flag_mismatch($sformatf("status %0d, wanted %0d",
                                            got.status, want.status));
                if (got.flash_address !== want.flash_address)
                    flag_mismatch($sformatf("flash_address %h, wanted %h",
                                            got.flash_address, want.flash_address));
                if (got.chunk_length !== want.chunk_length)
                    flag_mismatch($sformatf("chunk_length %0d, wanted %0d",
                                            got.chunk_length, want.chunk_length));
                if (want.status == ST_FOUND)
                    n_found++;
                else if (want.status == ST_MISS)
                    n_beyond++;
            end
        end
    end

    // Stimulus
    initial begin
        t_in_item    req;
        int unsigned p, k;
        logic [CFG_DATA_W-1:0] base_val;
        logic [CFG_DATA_W-1:0] count_val;

        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.item   = '0;
        out_ch.ready = 1'b0;
        out_hold     = 0;
        steady       = 1'b0;
        frag_count   = '0;
        frag_base    = FLASH_BASE_RESET;
        foreach (frag_table[k])
            frag_table[k] = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty map, field extremes, empty fragment, clamping, wrap
        script = '{
            mk_row(ROW_LOOKUP,    0,         0,         5,         1, ST_MISS,   0, 0),
            mk_row(ROW_LOAD,      0,         'h10,      2,         1, ST_LOADED, 0, 0),
            mk_row(ROW_LOAD,      1,         0,         0,         1, ST_LOADED, 0, 0),
            mk_row(ROW_LOAD,      2,         8191,      8191,      1, ST_LOADED, 0, 0),
            mk_row(ROW_LOAD,      3,         100,       1,         1, ST_LOADED, 0, 0),
            mk_row(ROW_LOAD,      1023,      8191,      8191,      1, ST_LOADED, 0, 0),
            mk_row(ROW_SET_COUNT, 4,         0,         0,         0, ST_LOADED, 0, 0),
            mk_row(ROW_LOOKUP,    0,         0,         'h1FFFFFF, 0, ST_LOADED, 0, 0),
            mk_row(ROW_LOOKUP,    0,         'h1FFF,    0,         1, ST_FOUND,
                   'hA001_1FFF, 0),
            mk_row(ROW_LOOKUP,    0,         'h2000,    'h1FFFFFF, 0, ST_LOADED, 0, 0),
            mk_row(ROW_LOOKUP,    0,         'h1FFFFFF, 'h1FFFFFF, 0, ST_LOADED, 0, 0),
            mk_row(ROW_LOOKUP,    0,         'h1ABCDE,  'h100,     0, ST_LOADED, 0, 0),
            mk_row(ROW_SET_COUNT, 1,         0,         0,         0, ST_LOADED, 0, 0),
            mk_row(ROW_LOOKUP,    0,         'h2000,    7,         1, ST_MISS,   0, 0),
            mk_row(ROW_LOOKUP,    0,         'h1FFF,    'h1FFFFFF, 0, ST_LOADED, 0, 0),
            mk_row(ROW_SET_BASE,  'hFFFFFFFF, 0,        0,         0, ST_LOADED, 0, 0),
            mk_row(ROW_SET_COUNT, 4,         0,         0,         0, ST_LOADED, 0, 0),
            mk_row(ROW_LOOKUP,    0,         'h1FFFFFF, 1,         0, ST_LOADED, 0, 0),
            mk_row(ROW_SET_BASE,  0,         0,         0,         0, ST_LOADED, 0, 0),
            mk_row(ROW_LOOKUP,    0,         'h3456,    'h1555555, 0, ST_LOADED, 0, 0),
            mk_row(ROW_LOAD,      3,         'h1555,    'hAAA,     1, ST_LOADED, 0, 0),
            mk_row(ROW_LOOKUP,    0,         'h0AAAAAA, 'h0AAAAAA, 0, ST_LOADED, 0, 0)
        };

        foreach (script[k]) begin
            case (script[k].kind)
                ROW_SET_COUNT: write_register(CFG_FRAGMENT_COUNT, script[k].arg);
                ROW_SET_BASE:  write_register(CFG_FLASH_BASE, script[k].arg);
                default: begin
                    req = make_request();
                    if (script[k].kind == ROW_LOAD) begin
                        req.action           = ACT_LOAD;
                        req.entry_index      = script[k].arg[IDX_W-1:0];
                        req.entry_first_page = script[k].arg_b[PAGE_W-1:0];
                        req.entry_page_count = script[k].arg_c[PAGE_W-1:0];
                    end else begin
                        req.action        = ACT_LOOKUP;
                        req.read_position = script[k].arg_b;
                        req.request_size  = script[k].arg_c;
                    end
                    send_request(req, pick_gap(), script[k].fixed, script[k].want);
                end
            endcase
        end

        // Fill the low slots, mostly empty fragments, so deep walks read loaded entries
        for (k = 0; k < FILL_SLOTS; k++) begin
            req = make_request();
            req.action           = ACT_LOAD;
            req.entry_index      = IDX_W'(k);
            req.entry_page_count = ($urandom_range(0, 7) == 0) ?
                                   PAGE_W'($urandom_range(1, 3)) : '0;
            send_request(req, pick_gap(), 1'b0, '0);
        end

        // Random phases; the first two walk deep, the rest stay short
        for (p = 0; p < 15; p++) begin
            steady = (p % 4 == 3);
            if (p == 0)
                count_val = FILL_SLOTS;
            else if (p == 1)
                count_val = $urandom_range(17, FILL_SLOTS - 1);
            else if (p % 5 == 2)
                count_val = 0;
            else
                count_val = $urandom_range(1, 16);
            case (p % 4)
                0:       base_val = FLASH_BASE_RESET;
                1:       base_val = $urandom;
                2:       base_val = '1;
                default: base_val = '0;
            endcase
            write_register(CFG_FLASH_BASE, base_val);
            write_register(CFG_FRAGMENT_COUNT, count_val);
            repeat ((p < 2) ? 20 : 17)
                send_request(make_request(), pick_gap(), 1'b0, '0);
        end
        steady = 1'b0;

        wait_until_idle();
        repeat (40) @(posedge i_clk);

        $display("covered %0d loads and %0d lookups: %0d found, %0d beyond the map",
                 n_loads, n_lookups, n_found, n_beyond);
        $display("%0d register writes, fragment counts from 0 to %0d, %0d mismatches",
                 n_reg_writes, FILL_SLOTS, n_errors);
        if (n_errors == 0)
            $display("fragment_map_address_translator regression: pass");
        else
            $display("fragment_map_address_translator regression: fail");
        $finish;
    end

endmodule
